FILE: src/pdps_pkg.sv
// Shared types, constants and command codes of the Poisson-disk point subsampler.
package pdps_pkg;

    localparam int COORD_BITS     = 20;
    localparam int CAPACITY_DEF   = 64;
    localparam int ITERATIONS_DEF = 30;
    localparam int TGT_W          = 7;
    localparam int TARGET_MAX     = 64;
    localparam int TARGET_RESET   = 16;
    localparam int NUM_W          = 64;
    localparam int RAD_W          = 32;
    localparam int FRAC_SHIFT     = 18;
    localparam int DIV_STEPS      = 64;
    localparam int SQRT_STEPS     = 32;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;
    localparam logic REG_TARGET   = 1'b0;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
        logic                         last;
    } t_in_beat;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic signed [COORD_BITS-1:0] out_z;
        logic                         out_last;
    } t_out_beat;

    typedef enum logic [4:0] {
        C_NONE, C_LOAD, C_FAST_INIT, C_NORM_INIT, C_NORM_RD, C_SQ_NORM, C_NORM_ACC,
        C_DIV_INIT, C_DIV_STEP, C_SQRT_INIT, C_SQRT_STEP, C_RINIT, C_RAD, C_RSQ, C_THR,
        C_P_RD, C_P_LAT, C_K_RD, C_K_ST, C_K_SQ, C_K_CMP, C_NEXT_I, C_KEEP, C_UPD,
        C_EM_INIT, C_EM_IDX, C_EM_RD, C_EM_OUT, C_FINISH
    } t_cmd;

    typedef enum logic [4:0] {
        S_LOAD, S_CHECK, S_NRD, S_NSQ, S_NACC, S_DIV_INIT, S_DIV, S_SQRT_INIT, S_SQRT,
        S_RINIT, S_RAD, S_RSQ, S_THR, S_PRD, S_PLAT, S_KCHK, S_KST, S_KSQ, S_KCMP,
        S_PEND, S_EM_IDX, S_EM_RD, S_EM_OUT, S_EM_WAIT
    } t_state;

    typedef struct packed {
        logic cnt_le_t;
        logic i_end;
        logic k_end;
        logic dist_lt_thr;
        logic div_end;
        logic sqrt_end;
        logic kept_eq_t;
        logic round_last;
        logic em_end;
    } t_stat;

endpackage

FILE: src/pdps_ctrl.sv
// Sequencer of the subsampler: loading, norm pass, divide, square root, bisection, emission.
module pdps_ctrl
    import pdps_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_last,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_stall,
    output logic  o_out_valid
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:      if (i_in_valid && i_in_last) n_state = S_CHECK;
            S_CHECK:     n_state = i_stat.cnt_le_t ? S_EM_IDX : S_NRD;
            S_NRD:       n_state = S_NSQ;
            S_NSQ:       n_state = S_NACC;
            S_NACC:      n_state = i_stat.i_end ? S_DIV_INIT : S_NRD;
            S_DIV_INIT:  n_state = S_DIV;
            S_DIV:       if (i_stat.div_end) n_state = S_SQRT_INIT;
            S_SQRT_INIT: n_state = S_SQRT;
            S_SQRT:      if (i_stat.sqrt_end) n_state = S_RINIT;
            S_RINIT:     n_state = S_RAD;
            S_RAD:       n_state = S_RSQ;
            S_RSQ:       n_state = S_THR;
            S_THR:       n_state = S_PRD;
            S_PRD:       n_state = i_stat.i_end ? S_PEND : S_PLAT;
            S_PLAT:      n_state = S_KCHK;
            S_KCHK:      n_state = i_stat.k_end ? S_PRD : S_KST;
            S_KST:       n_state = S_KSQ;
            S_KSQ:       n_state = S_KCMP;
            S_KCMP:      n_state = i_stat.dist_lt_thr ? S_PRD : S_KCHK;
            S_PEND:      n_state = (i_stat.kept_eq_t || i_stat.round_last) ? S_EM_IDX : S_RAD;
            S_EM_IDX:    n_state = S_EM_RD;
            S_EM_RD:     n_state = S_EM_OUT;
            S_EM_OUT:    n_state = S_EM_WAIT;
            S_EM_WAIT:   if (!i_out_stall) n_state = i_stat.em_end ? S_LOAD : S_EM_IDX;
            default:     n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd       = C_NONE;
        o_in_stall  = (r_state != S_LOAD);
        o_out_valid = (r_state == S_EM_WAIT);
        unique case (r_state)
            S_LOAD:      if (i_in_valid) o_cmd = C_LOAD;
            S_CHECK:     o_cmd = i_stat.cnt_le_t ? C_FAST_INIT : C_NORM_INIT;
            S_NRD:       o_cmd = C_NORM_RD;
            S_NSQ:       o_cmd = C_SQ_NORM;
            S_NACC:      o_cmd = C_NORM_ACC;
            S_DIV_INIT:  o_cmd = C_DIV_INIT;
            S_DIV:       o_cmd = C_DIV_STEP;
            S_SQRT_INIT: o_cmd = C_SQRT_INIT;
            S_SQRT:      o_cmd = C_SQRT_STEP;
            S_RINIT:     o_cmd = C_RINIT;
            S_RAD:       o_cmd = C_RAD;
            S_RSQ:       o_cmd = C_RSQ;
            S_THR:       o_cmd = C_THR;
            S_PRD:       o_cmd = i_stat.i_end ? C_NONE : C_P_RD;
            S_PLAT:      o_cmd = C_P_LAT;
            S_KCHK:      o_cmd = i_stat.k_end ? C_KEEP : C_K_RD;
            S_KST:       o_cmd = C_K_ST;
            S_KSQ:       o_cmd = C_K_SQ;
            S_KCMP:      o_cmd = i_stat.dist_lt_thr ? C_NEXT_I : C_K_CMP;
            S_PEND:      o_cmd = (i_stat.kept_eq_t || i_stat.round_last) ? C_EM_INIT : C_UPD;
            S_EM_IDX:    o_cmd = C_EM_IDX;
            S_EM_RD:     o_cmd = C_EM_RD;
            S_EM_OUT:    o_cmd = C_EM_OUT;
            S_EM_WAIT:   if (!i_out_stall && i_stat.em_end) o_cmd = C_FINISH;
            default:     o_cmd = C_NONE;
        endcase
    end

endmodule

FILE: src/pdps_dp.sv
// Datapath of the subsampler: point and kept-index memories, distance unit, divider, root.
module pdps_dp
    import pdps_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int ITERATIONS = ITERATIONS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_in_beat         i_in_beat,
    input  logic             i_cfg_wr,
    input  logic [TGT_W-1:0] i_cfg_data,
    output logic [TGT_W-1:0] o_target,
    output t_stat            o_stat,
    output t_out_beat        o_out_beat
);

    localparam int CB   = COORD_BITS;
    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int RW   = $clog2(ITERATIONS + 1);
    localparam int MW   = CB + 1;
    localparam int SQW  = 2 * MW;
    localparam int SW   = SQW + 2;
    localparam int CMPW = (CW > TGT_W) ? CW : TGT_W;

    logic [3*CB-1:0] r_store [CAPACITY];
    logic [IW-1:0]   r_klist [CAPACITY];

    logic [TGT_W-1:0] r_target;
    logic [CW-1:0]    r_cnt, r_i, r_k, r_kept, r_nemit;
    logic [IW-1:0]    r_kidx;
    logic [3*CB-1:0]  r_rd, r_pi;
    logic [SQW-1:0]   r_sq [3];
    logic [SW-1:0]    r_maxsq;
    logic [NUM_W-1:0] r_quo, r_sn, r_res, r_sbit, r_rsq, r_thr;
    logic [TGT_W-1:0] r_rem;
    logic [5:0]       r_step;
    logic [RAD_W-1:0] r_rlo, r_rhi, r_r;
    logic [RW-1:0]    r_round;
    logic             r_fast;
    t_out_beat        r_out;

    logic [TGT_W-1:0] t_eff;
    logic [IW-1:0]    rd_addr;
    logic             rd_en;
    logic [SW-1:0]    dsum;
    logic [TGT_W:0]   rem_sh;
    logic [NUM_W-1:0] sq_try;
    logic [RAD_W:0]   rad_sum;
    logic             kept_lt_t;

    assign t_eff = (r_target == '0) ? TGT_W'(1) :
                   (r_target > TGT_W'(TARGET_MAX)) ? TGT_W'(TARGET_MAX) : r_target;
    assign o_target   = r_target;
    assign o_out_beat = r_out;

    // Squared-distance unit: operand a is the stored read, b the current point or zero.
    always_ff @(posedge i_clk) begin
        logic signed [CB-1:0] a, b;
        logic        [MW-1:0] d, m;
        for (int c = 0; c < 3; c++) begin
            a = r_rd[(2-c)*CB +: CB];
            b = (i_cmd == C_K_SQ) ? r_pi[(2-c)*CB +: CB] : '0;
            d = {a[CB-1], a} - {b[CB-1], b};
            m = d[MW-1] ? (~d + MW'(1)) : d;
            if (i_cmd == C_SQ_NORM || i_cmd == C_K_SQ) r_sq[c] <= m * m;
        end
    end

    assign dsum      = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
    assign rem_sh    = {r_rem, r_quo[NUM_W-1]};
    assign sq_try    = r_res + r_sbit;
    assign rad_sum   = {1'b0, r_rlo} + {1'b0, r_rhi};
    assign kept_lt_t = CMPW'(r_kept) < CMPW'(t_eff);

    assign rd_en   = (i_cmd == C_NORM_RD) || (i_cmd == C_P_RD) ||
                     (i_cmd == C_K_ST) || (i_cmd == C_EM_RD);
    assign rd_addr = (i_cmd == C_NORM_RD || i_cmd == C_P_RD) ? r_i[IW-1:0] : r_kidx;

    always_ff @(posedge i_clk) begin
        if (i_cmd == C_LOAD && r_cnt < CW'(CAPACITY))
            r_store[r_cnt[IW-1:0]] <= {i_in_beat.coord_x, i_in_beat.coord_y, i_in_beat.coord_z};
        if (rd_en) r_rd <= r_store[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == C_KEEP && r_kept < CW'(CAPACITY)) r_klist[r_kept[IW-1:0]] <= r_i[IW-1:0];
        if (i_cmd == C_K_RD) r_kidx <= r_klist[r_k[IW-1:0]];
        if (i_cmd == C_EM_IDX) r_kidx <= r_fast ? r_k[IW-1:0] : r_klist[r_k[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TGT_W'(TARGET_RESET);
            r_cnt    <= '0;
            r_kept   <= '0;
            r_maxsq  <= '0;
            r_rlo    <= '0;
            r_rhi    <= '0;
            r_round  <= '0;
            r_fast   <= 1'b0;
        end else begin
            if (i_cfg_wr) r_target <= i_cfg_data;
            case (i_cmd)
                C_LOAD:      if (r_cnt < CW'(CAPACITY)) r_cnt <= r_cnt + CW'(1);
                C_FAST_INIT: begin
                    r_fast  <= 1'b1;
                    r_k     <= '0;
                    r_nemit <= r_cnt;
                end
                C_NORM_INIT: begin
                    r_fast  <= 1'b0;
                    r_i     <= '0;
                    r_maxsq <= '0;
                end
                C_NORM_RD:   r_i <= r_i + CW'(1);
                C_NORM_ACC:  if (dsum > r_maxsq) r_maxsq <= dsum;
                C_DIV_INIT: begin
                    r_quo  <= NUM_W'({r_maxsq, FRAC_SHIFT'(0)});
                    r_rem  <= '0;
                    r_step <= '0;
                end
                C_DIV_STEP: begin
                    r_step <= r_step + 6'd1;
                    if (rem_sh >= {1'b0, t_eff}) begin
                        r_rem <= TGT_W'(rem_sh - {1'b0, t_eff});
                        r_quo <= {r_quo[NUM_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[TGT_W-1:0];
                        r_quo <= {r_quo[NUM_W-2:0], 1'b0};
                    end
                end
                C_SQRT_INIT: begin
                    r_sn   <= r_quo;
                    r_res  <= '0;
                    r_sbit <= NUM_W'(1) << (NUM_W - 2);
                    r_step <= '0;
                end
                C_SQRT_STEP: begin
                    r_step <= r_step + 6'd1;
                    r_sbit <= r_sbit >> 2;
                    if (r_sn >= sq_try) begin
                        r_sn  <= r_sn - sq_try;
                        r_res <= (r_res >> 1) + r_sbit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                end
                C_RINIT: begin
                    r_rhi   <= r_res[RAD_W-1:0];
                    r_rlo   <= '0;
                    r_round <= '0;
                end
                C_RAD:   r_r   <= rad_sum[RAD_W:1];
                C_RSQ:   r_rsq <= NUM_W'(r_r) * NUM_W'(r_r);
                C_THR: begin
                    r_thr  <= NUM_W'(r_rsq[NUM_W-1:16]) + NUM_W'(|r_rsq[15:0]);
                    r_kept <= '0;
                    r_i    <= '0;
                end
                C_P_RD:   r_k  <= '0;
                C_P_LAT:  r_pi <= r_rd;
                C_K_CMP:  r_k  <= r_k + CW'(1);
                C_NEXT_I: r_i  <= r_i + CW'(1);
                C_KEEP: begin
                    if (r_kept < CW'(CAPACITY)) r_kept <= r_kept + CW'(1);
                    r_i <= r_i + CW'(1);
                end
                C_UPD: begin
                    if (kept_lt_t) r_rhi <= r_r;
                    else r_rlo <= r_r;
                    r_round <= r_round + RW'(1);
                end
                C_EM_INIT: begin
                    r_k     <= '0;
                    r_nemit <= kept_lt_t ? r_kept : CW'(t_eff);
                end
                C_EM_OUT: begin
                    r_out.out_x    <= r_rd[3*CB-1 -: CB];
                    r_out.out_y    <= r_rd[2*CB-1 -: CB];
                    r_out.out_z    <= r_rd[CB-1:0];
                    r_out.out_last <= (r_k + CW'(1)) == r_nemit;
                    r_k            <= r_k + CW'(1);
                end
                C_FINISH: r_cnt <= '0;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.cnt_le_t    = CMPW'(r_cnt) <= CMPW'(t_eff);
        o_stat.i_end       = r_i == r_cnt;
        o_stat.k_end       = r_k == r_kept;
        o_stat.dist_lt_thr = NUM_W'(dsum) < r_thr;
        o_stat.div_end     = r_step == 6'(DIV_STEPS - 1);
        o_stat.sqrt_end    = r_step[4:0] == 5'(SQRT_STEPS - 1);
        o_stat.kept_eq_t   = CMPW'(r_kept) == CMPW'(t_eff);
        o_stat.round_last  = r_round == RW'(ITERATIONS - 1);
        o_stat.em_end      = r_k == r_nemit;
    end

endmodule

FILE: src/poisson_disk_point_subsampler_top.sv
// Top level of the Poisson-disk point subsampler with radius bisection.
//
// Usage: candidate points arrive as input beats on i_in_valid / o_in_stall, one beat
// per cycle while the block is loading. A beat with last set closes the set and
// starts the computation; o_in_stall stays high until every result beat is taken.
// Result beats leave on o_out_valid / i_out_stall from an output register; the
// final one carries out_last. A stalled result holds until it is taken.
// Sets no larger than target_count are replayed unchanged. Larger sets first take a
// norm pass, a divider and a square root. Each bisection round then reads each
// candidate and the kept points it is compared with through the single read port
// of the point memory, which serves both; up to ITERATIONS rounds run. Emission
// waits on receiver stalls. Reset returns the block to loading with an empty set
// and target_count at 16; the memories need no clearing, since only entries of
// the current set are read. target_count must be written over the register port
// only while the block is idle; the block itself does not enforce this.
module poisson_disk_point_subsampler_top
    import pdps_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int ITERATIONS = ITERATIONS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_beat          i_in_beat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_beat         o_out_beat,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cmd             cmd;
    t_stat            stat;
    logic             cfg_wr;
    logic [TGT_W-1:0] target;

    // The register is selected by its word address; byte offsets are ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TARGET);
    assign prdata = (paddr[2] == REG_TARGET) ? DATA_W'(target) : '0;

    pdps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_beat.last),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    pdps_dp #(
        .CAPACITY   (CAPACITY),
        .ITERATIONS (ITERATIONS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_beat  (i_in_beat),
        .i_cfg_wr   (cfg_wr),
        .i_cfg_data (pwdata[TGT_W-1:0]),
        .o_target   (target),
        .o_stat     (stat),
        .o_out_beat (o_out_beat)
    );

endmodule

FILE: src/pdps_checker.sv
// Port-level checks of the subsampler and their binding to the top level.
module pdps_checker
    import pdps_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_beat  i_in_beat,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_beat
);

    // No candidate is taken while results of the set are being delivered.
    a_no_load_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted during emission");

    // The beat that closes a set stops further loading.
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_beat.last) |=> o_in_stall)
        else $error("loading continued after last beat");

    // A stalled result stays presented and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_beat)))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind poisson_disk_point_subsampler_top pdps_checker u_pdps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_beat   (i_in_beat),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

FILE: test/poisson_disk_point_subsampler_top_tb.sv
// Testbench for the Poisson-disk point subsampler: directed and random point sets checked against a predictor.
`timescale 1ns / 100ps

module poisson_disk_point_subsampler_top_tb
    import pdps_pkg::*;
();

    localparam int CAP         = CAPACITY_DEF;
    localparam int ROUNDS      = ITERATIONS_DEF;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE      = 200;
    localparam int HOLD_CYCLES = 400;
    localparam logic [ADDR_W-1:0] TARGET_ADDR = ADDR_W'(REG_TARGET) << 2;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_beat          i_in_beat;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_beat         o_out_beat;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    poisson_disk_point_subsampler_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_beat (o_out_beat),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Pending input beats, and the point beats the block should emit.
    t_in_beat  cand_q[$];
    t_out_beat kept_pts_q[$];

    int errors;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_start;
    bit hold_served;
    int hold_left;
    bit in_taken;

    // Shadow of the block's state as seen by the predictor.
    logic signed [COORD_BITS-1:0] set_pts[CAP][3];
    int                           set_count;
    int                           sel_idx[CAP];
    int                           sel_count;
    logic [TGT_W-1:0]             target_shadow;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Integer square root by the usual bit-pair method.
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned pair_dist_sq(int a, int b);
        longint unsigned s;
        longint          d;
        s = 0;
        for (int c = 0; c < 3; c++) begin
            d = longint'(set_pts[a][c]) - longint'(set_pts[b][c]);
            if (d < 0) d = -d;
            s = s + longint'(d) * longint'(d);
        end
        return s;
    endfunction

    // One greedy pass in arrival order at squared-distance threshold thr.
    task automatic greedy_select(longint unsigned thr);
        bit ok;
        sel_count = 0;
        for (int i = 0; i < set_count; i++) begin
            ok = 1'b1;
            for (int k = 0; k < sel_count; k++) begin
                if (pair_dist_sq(i, sel_idx[k]) < thr) begin
                    ok = 1'b0;
                    break;
                end
            end
            if (ok && sel_count < CAP) begin
                sel_idx[sel_count] = i;
                sel_count++;
            end
        end
    endtask

    // Works out the emitted points of a closed set and queues them.
    task automatic predict_subsample();
        int              tgt;
        int              n;
        longint unsigned max_sq;
        longint unsigned norm;
        longint unsigned r_lo;
        longint unsigned r_hi;
        longint unsigned r;
        longint unsigned rsq;
        longint unsigned thr;
        t_out_beat       ob;
        tgt = int'(target_shadow);
        if (tgt < 1) tgt = 1;
        if (tgt > TARGET_MAX) tgt = TARGET_MAX;
        if (set_count <= tgt) begin
            sel_count = set_count;
            for (int i = 0; i < set_count; i++) sel_idx[i] = i;
            n = set_count;
        end else begin
            max_sq = 0;
            for (int i = 0; i < set_count; i++) begin
                norm = 0;
                for (int c = 0; c < 3; c++)
                    norm = norm + longint'(set_pts[i][c]) * longint'(set_pts[i][c]);
                if (norm > max_sq) max_sq = norm;
            end
            r_hi = int_sqrt((max_sq << 18) / longint'(tgt)) & 64'hFFFF_FFFF;
            r_lo = 0;
            for (int rc = 0; rc < ROUNDS; rc++) begin
                r   = (r_lo + r_hi) >> 1;
                rsq = r * r;
                thr = (rsq >> 16) + ((rsq[15:0] != 0) ? 1 : 0);
                greedy_select(thr);
                if (sel_count == tgt) break;
                if (sel_count < tgt) r_hi = r;
                else r_lo = r;
            end
            n = (sel_count < tgt) ? sel_count : tgt;
        end
        for (int k = 0; k < n; k++) begin
            ob.out_x    = set_pts[sel_idx[k]][0];
            ob.out_y    = set_pts[sel_idx[k]][1];
            ob.out_z    = set_pts[sel_idx[k]][2];
            ob.out_last = (k + 1 == n);
            kept_pts_q  = {kept_pts_q, ob};
        end
        set_count = 0;
    endtask

    task automatic log_mismatch(string what, longint exp_v, longint act_v);
        if (errors < 10)
            $display("mismatch %s: expected %0d, got %0d at cycle %0d", what, exp_v, act_v, cycles);
        errors++;
    endtask

    // Input side: note accepted beats and feed them to the predictor.
    always @(posedge i_clk) begin
        in_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (set_count < CAP) begin
                set_pts[set_count][0] = i_in_beat.coord_x;
                set_pts[set_count][1] = i_in_beat.coord_y;
                set_pts[set_count][2] = i_in_beat.coord_z;
                set_count++;
            end
            if (i_in_beat.last) predict_subsample();
        end
    end

    // Driver: a beat holds until taken, then the next one may follow after a random gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (cand_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_beat  <= cand_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that starts on the first result offered once hold_start is set.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_start && !hold_served && o_out_valid) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_served <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Monitor: every accepted result beat is checked field by field against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_beat ex;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (kept_pts_q.size() == 0) begin
                log_mismatch("unexpected result beat, out_x", 0, o_out_beat.out_x);
            end else begin
                ex = kept_pts_q.pop_front();
                if (o_out_beat.out_x !== ex.out_x) log_mismatch("out_x", ex.out_x, o_out_beat.out_x);
                if (o_out_beat.out_y !== ex.out_y) log_mismatch("out_y", ex.out_y, o_out_beat.out_y);
                if (o_out_beat.out_z !== ex.out_z) log_mismatch("out_z", ex.out_z, o_out_beat.out_z);
                if (o_out_beat.out_last !== ex.out_last)
                    log_mismatch("out_last", ex.out_last, o_out_beat.out_last);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic signed [COORD_BITS-1:0] pick_coord(int style);
        case (style)
            0: return COORD_BITS'($urandom());
            1: return COORD_BITS'($urandom_range(0, 400)) - COORD_BITS'(200);
            default: begin
                case ($urandom_range(0, 3))
                    0: return {1'b1, {(COORD_BITS-1){1'b0}}};
                    1: return {1'b0, {(COORD_BITS-1){1'b1}}};
                    2: return '0;
                    default: return COORD_BITS'($urandom());
                endcase
            end
        endcase
    endfunction

    task automatic add_point(logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
                             logic signed [COORD_BITS-1:0] z, logic lst);
        t_in_beat b;
        b.coord_x = x;
        b.coord_y = y;
        b.coord_z = z;
        b.last    = lst;
        cand_q    = {cand_q, b};
    endtask

    // Queues a whole set; planar sets keep z at zero.
    task automatic add_set(int n, int style, bit planar);
        for (int i = 0; i < n; i++)
            add_point(pick_coord(style), pick_coord(style), planar ? '0 : pick_coord(style),
                      i == n - 1);
    endtask

    // Waits until every beat is sent and every result has arrived, then lets the block settle.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (cand_q.size() != 0 || i_in_valid || kept_pts_q.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Register write followed by a read-back of the same register.
    task automatic set_target(logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] rd;
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= TARGET_ADDR;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        target_shadow = value[TGT_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[TGT_W-1:0] !== target_shadow)
            log_mismatch("target_count read-back", target_shadow, rd[TGT_W-1:0]);
    endtask

    task automatic random_phase(int items, bit pressure);
        int sent;
        int n;
        int pick;
        sent = 0;
        if (pressure) begin
            // The receiver holds off on the results of a full-capacity set with overflow,
            // while the next set is already offered at the input.
            set_target(TARGET_MAX);
            hold_start = 1'b1;
            add_set(CAP + 2, 0, 1'b0);
            sent += CAP + 2;
            add_set(8, 1, 1'b0);
            sent += 8;
        end
        while (sent < items) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: set_target(0);
                1: set_target(1);
                2: set_target(TARGET_MAX);
                3: set_target(127);
                4: set_target($urandom_range(2, 6));
                default: ;
            endcase
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 24) : $urandom_range(1, 12);
            add_set(n, $urandom_range(0, 2), $urandom_range(0, 3) == 0);
            sent += n;
        end
    endtask

    initial begin
        logic signed [COORD_BITS-1:0] mx;
        logic signed [COORD_BITS-1:0] mn;
        mx            = {1'b0, {(COORD_BITS-1){1'b1}}};
        mn            = {1'b1, {(COORD_BITS-1){1'b0}}};
        errors        = 0;
        cycles        = 0;
        set_count     = 0;
        sel_count     = 0;
        target_shadow = TGT_W'(TARGET_RESET);
        send_idle_pct = 7;
        recv_idle_pct = 84;
        hold_start    = 1'b0;
        hold_served   = 1'b0;
        hold_left     = 0;
        in_taken      = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_beat     = '0;
        i_out_stall   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: a single point at the reset target.
        add_point(mx, mn, '0, 1'b1);
        // Extremes and a duplicate pair, still at or below the target.
        add_point(mn, mn, mn, 1'b0);
        add_point(mx, mx, mx, 1'b0);
        add_point('0, '0, '0, 1'b0);
        add_point('0, '0, '0, 1'b1);
        // Cube corners with a duplicate, bisected down to two points.
        set_target(2);
        for (int i = 0; i < 8; i++)
            add_point(i[0] ? mx : mn, i[1] ? mx : mn, i[2] ? mx : mn, 1'b0);
        add_point(mx, mx, mx, 1'b1);
        // A target of zero acts as one.
        set_target(0);
        add_point(COORD_BITS'(5), COORD_BITS'(-3), '0, 1'b0);
        add_point(mx, '0, mn, 1'b0);
        add_point(COORD_BITS'(5), COORD_BITS'(-3), '0, 1'b1);
        // A target above the maximum acts as the maximum.
        set_target(127);
        add_set(5, 2, 1'b0);

        // Random: sender sparse gaps and a busy receiver, then swapped, then no idling.
        random_phase(50, 1'b0);
        send_idle_pct = 84;
        recv_idle_pct = 7;
        random_phase(70, 1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(45, 1'b0);
        set_target(TARGET_RESET);
        add_set(20, 1, 1'b0);

        wait_idle();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
src/pdps_pkg.sv
src/pdps_ctrl.sv
src/pdps_dp.sv
src/poisson_disk_point_subsampler_top.sv
src/pdps_checker.sv
test/poisson_disk_point_subsampler_top_tb.sv
